/* rtl/qvr_pkg.sv */
// qvr_pkg: shared types and constants of the quaternion vector rotator.
// No dependencies; used by qvr_matrix and quaternion_vector_rotator.
`timescale 1ns / 1ps

package qvr_pkg;

  // Field widths
  localparam int unsigned QuatW   = 16;           // Q2.14 quaternion component
  localparam int unsigned VecW    = 32;           // Q16.16 vector component
  localparam int unsigned ProdW   = 32;           // quaternion component product
  localparam int unsigned MatW    = 34;           // matrix entry, Q.28, exact
  localparam int unsigned HalfW   = 16;           // split of a vector component
  localparam int unsigned PpW     = 51;           // matrix entry times half word
  localparam int unsigned RowW    = 53;           // sum of three partial products
  localparam int unsigned AccW    = 70;           // full row sum, scale 2^44
  localparam int unsigned FracDrop = 28;          // bits dropped by the final rounding
  localparam int unsigned ResW    = AccW - FracDrop;
  localparam int unsigned CfgIdxW = 2;

  // Rounding bias: half of the dropped scale
  localparam logic signed [AccW-1:0] RoundBias = AccW'(1) <<< (FracDrop - 1);

  // Identity quaternion and its products
  localparam logic signed [QuatW-1:0] QuatOne = 16'sd16384;
  localparam logic signed [ProdW-1:0] ProdOne = 32'sd268435456;
  localparam logic signed [MatW-1:0]  MatOne  = 34'sd268435456;

  localparam logic signed [VecW-1:0] VecMax = 32'sh7fff_ffff;
  localparam logic signed [VecW-1:0] VecMin = 32'sh8000_0000;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_QUAT_W = 2'd0,
    CFG_QUAT_X = 2'd1,
    CFG_QUAT_Y = 2'd2,
    CFG_QUAT_Z = 2'd3
  } cfg_idx_e;

  typedef logic signed [QuatW-1:0] quat_t;
  typedef logic signed [VecW-1:0]  vec_t;
  typedef logic signed [MatW-1:0]  ment_t;
  typedef logic signed [PpW-1:0]   pp_t;
  typedef logic signed [RowW-1:0]  row_t;

  // All pairwise quaternion products that the matrix needs
  typedef struct packed {
    logic signed [ProdW-1:0] ww;
    logic signed [ProdW-1:0] xx;
    logic signed [ProdW-1:0] yy;
    logic signed [ProdW-1:0] zz;
    logic signed [ProdW-1:0] xy;
    logic signed [ProdW-1:0] xz;
    logic signed [ProdW-1:0] yz;
    logic signed [ProdW-1:0] wx;
    logic signed [ProdW-1:0] wy;
    logic signed [ProdW-1:0] wz;
  } prod_t;

  // Rotation matrix, row-major, entries Q.28
  typedef struct packed {
    ment_t m00; ment_t m01; ment_t m02;
    ment_t m10; ment_t m11; ment_t m12;
    ment_t m20; ment_t m21; ment_t m22;
  } mat_t;

endpackage

/* rtl/qvr_matrix.sv */
// qvr_matrix: quaternion configuration registers and the rotation matrix built from them.
// Depends on qvr_pkg.
`timescale 1ns / 1ps

module qvr_matrix (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [qvr_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [qvr_pkg::QuatW-1:0]     cfg_wdata_i,
  output qvr_pkg::mat_t                 mat_o
);

  qvr_pkg::quat_t w_q, x_q, y_q, z_q;
  qvr_pkg::quat_t w_d, x_d, y_d, z_d;
  qvr_pkg::prod_t prod_q, prod_d;
  qvr_pkg::mat_t  mat_q, mat_d;

  // Register write decode
  always_comb begin
    w_d = w_q;
    x_d = x_q;
    y_d = y_q;
    z_d = z_q;
    if (cfg_we_i) begin
      case (qvr_pkg::cfg_idx_e'(cfg_idx_i))
        qvr_pkg::CFG_QUAT_W: w_d = $signed(cfg_wdata_i);
        qvr_pkg::CFG_QUAT_X: x_d = $signed(cfg_wdata_i);
        qvr_pkg::CFG_QUAT_Y: y_d = $signed(cfg_wdata_i);
        qvr_pkg::CFG_QUAT_Z: z_d = $signed(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  // Products taken from the next register values, so they settle with the write
  always_comb begin
    prod_d.ww = qvr_pkg::ProdW'(w_d) * qvr_pkg::ProdW'(w_d);
    prod_d.xx = qvr_pkg::ProdW'(x_d) * qvr_pkg::ProdW'(x_d);
    prod_d.yy = qvr_pkg::ProdW'(y_d) * qvr_pkg::ProdW'(y_d);
    prod_d.zz = qvr_pkg::ProdW'(z_d) * qvr_pkg::ProdW'(z_d);
    prod_d.xy = qvr_pkg::ProdW'(x_d) * qvr_pkg::ProdW'(y_d);
    prod_d.xz = qvr_pkg::ProdW'(x_d) * qvr_pkg::ProdW'(z_d);
    prod_d.yz = qvr_pkg::ProdW'(y_d) * qvr_pkg::ProdW'(z_d);
    prod_d.wx = qvr_pkg::ProdW'(w_d) * qvr_pkg::ProdW'(x_d);
    prod_d.wy = qvr_pkg::ProdW'(w_d) * qvr_pkg::ProdW'(y_d);
    prod_d.wz = qvr_pkg::ProdW'(w_d) * qvr_pkg::ProdW'(z_d);
  end

  // Matrix entries: diagonal signed sums of squares, off-diagonal doubled sums/differences
  always_comb begin
    qvr_pkg::ment_t ww, xx, yy, zz, xy, xz, yz, wx, wy, wz;
    ww = qvr_pkg::MatW'(prod_q.ww);
    xx = qvr_pkg::MatW'(prod_q.xx);
    yy = qvr_pkg::MatW'(prod_q.yy);
    zz = qvr_pkg::MatW'(prod_q.zz);
    xy = qvr_pkg::MatW'(prod_q.xy);
    xz = qvr_pkg::MatW'(prod_q.xz);
    yz = qvr_pkg::MatW'(prod_q.yz);
    wx = qvr_pkg::MatW'(prod_q.wx);
    wy = qvr_pkg::MatW'(prod_q.wy);
    wz = qvr_pkg::MatW'(prod_q.wz);
    mat_d.m00 = ww + xx - yy - zz;
    mat_d.m01 = (xy - wz) <<< 1;
    mat_d.m02 = (xz + wy) <<< 1;
    mat_d.m10 = (xy + wz) <<< 1;
    mat_d.m11 = ww - xx + yy - zz;
    mat_d.m12 = (yz - wx) <<< 1;
    mat_d.m20 = (xz - wy) <<< 1;
    mat_d.m21 = (yz + wx) <<< 1;
    mat_d.m22 = ww - xx - yy + zz;
  end

  // Reset leaves the identity rotation in every register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q    <= qvr_pkg::QuatOne;
      x_q    <= '0;
      y_q    <= '0;
      z_q    <= '0;
      prod_q <= '{ww: qvr_pkg::ProdOne, default: '0};
      mat_q  <= '{m00: qvr_pkg::MatOne, m11: qvr_pkg::MatOne, m22: qvr_pkg::MatOne,
                  default: '0};
    end else begin
      w_q    <= w_d;
      x_q    <= x_d;
      y_q    <= y_d;
      z_q    <= z_d;
      prod_q <= prod_d;
      mat_q  <= mat_d;
    end
  end

  assign mat_o = mat_q;

endmodule

/* rtl/quaternion_vector_rotator.sv */
// Rotates a stream of Q16.16 vectors by the configured Q2.14 quaternion.
// Depends on qvr_pkg and qvr_matrix.
//
// One vector enters per clock while in_stall_o is low; each gives one result
// via input register, partial products, row sums, rounding and saturation.
// A vector is split into a signed high and an unsigned low half word, so each
// matrix entry is multiplied by 17-bit operands only; the nine matrix entries
// and eighteen such multipliers set the cost. Quaternion writes are registered
// with their products, then the matrix; send vectors from the next cycle on.
// Stalls hold each stage only where the one behind it is full, so bubbles
// are squeezed out. Results are rounded to nearest (ties up) and clamped to
// the Q16.16 limits, with clipped set when any component was clamped.
`timescale 1ns / 1ps

module quaternion_vector_rotator (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Configuration write port
  input  logic                         cfg_we_i,
  input  logic [qvr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [qvr_pkg::QuatW-1:0]    cfg_wdata_i,
  // Input requests
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [qvr_pkg::VecW-1:0] in_x_i,
  input  logic signed [qvr_pkg::VecW-1:0] in_y_i,
  input  logic signed [qvr_pkg::VecW-1:0] in_z_i,
  input  logic                         last_in_i,
  // Result requests
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [qvr_pkg::VecW-1:0] out_x_o,
  output logic signed [qvr_pkg::VecW-1:0] out_y_o,
  output logic signed [qvr_pkg::VecW-1:0] out_z_o,
  output logic                         clipped_o,
  output logic                         last_out_o
);

  qvr_pkg::mat_t mat;
  qvr_pkg::ment_t m [3][3];

  qvr_matrix u_matrix (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .mat_o       (mat)
  );

  assign m[0][0] = mat.m00;
  assign m[0][1] = mat.m01;
  assign m[0][2] = mat.m02;
  assign m[1][0] = mat.m10;
  assign m[1][1] = mat.m11;
  assign m[1][2] = mat.m12;
  assign m[2][0] = mat.m20;
  assign m[2][1] = mat.m21;
  assign m[2][2] = mat.m22;

  // Stage valids and per-stage advance enables
  logic v1_q, v2_q, v3_q, v4_q;
  logic en1, en2, en3, en4;

  assign en4 = !v4_q || !out_stall_i;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_stall_o = !en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  // Stage 1: input capture
  qvr_pkg::vec_t vec_q [3];
  logic          last1_q;

  always_ff @(posedge clk_i) begin
    if (en1) begin
      vec_q[0] <= in_x_i;
      vec_q[1] <= in_y_i;
      vec_q[2] <= in_z_i;
      last1_q  <= last_in_i;
    end
  end

  // Stage 2: matrix entry times high and low half words
  qvr_pkg::pp_t pph_d [3][3];
  qvr_pkg::pp_t ppl_d [3][3];
  qvr_pkg::pp_t pph_q [3][3];
  qvr_pkg::pp_t ppl_q [3][3];
  logic         last2_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        pph_d[i][j] = qvr_pkg::PpW'(m[i][j])
                    * qvr_pkg::PpW'($signed(vec_q[j][qvr_pkg::VecW-1:qvr_pkg::HalfW]));
        ppl_d[i][j] = qvr_pkg::PpW'(m[i][j])
                    * $signed({{(qvr_pkg::PpW-qvr_pkg::HalfW){1'b0}},
                               vec_q[j][qvr_pkg::HalfW-1:0]});
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      pph_q   <= pph_d;
      ppl_q   <= ppl_d;
      last2_q <= last1_q;
    end
  end

  // Stage 3: row sums of high and low partial products
  qvr_pkg::row_t sh_d [3];
  qvr_pkg::row_t sl_d [3];
  qvr_pkg::row_t sh_q [3];
  qvr_pkg::row_t sl_q [3];
  logic          last3_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sh_d[i] = qvr_pkg::RowW'(pph_q[i][0]) + qvr_pkg::RowW'(pph_q[i][1])
              + qvr_pkg::RowW'(pph_q[i][2]);
      sl_d[i] = qvr_pkg::RowW'(ppl_q[i][0]) + qvr_pkg::RowW'(ppl_q[i][1])
              + qvr_pkg::RowW'(ppl_q[i][2]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      sh_q    <= sh_d;
      sl_q    <= sl_d;
      last3_q <= last2_q;
    end
  end

  // Stage 4: recombine, round to nearest (ties up), saturate
  qvr_pkg::vec_t res_d [3];
  logic [2:0]    clip_d;
  qvr_pkg::vec_t res_q [3];
  logic          clip_q, last4_q;

  always_comb begin
    logic signed [qvr_pkg::AccW-1:0] acc;
    logic signed [qvr_pkg::ResW-1:0] r;
    logic [qvr_pkg::ResW-qvr_pkg::VecW:0] hi;
    for (int i = 0; i < 3; i++) begin
      acc = (qvr_pkg::AccW'(sh_q[i]) <<< qvr_pkg::HalfW) + qvr_pkg::AccW'(sl_q[i])
          + qvr_pkg::RoundBias;
      r   = acc[qvr_pkg::AccW-1:qvr_pkg::FracDrop];
      hi  = r[qvr_pkg::ResW-1:qvr_pkg::VecW-1];
      clip_d[i] = !(&hi) && (|hi);
      if (clip_d[i]) begin
        res_d[i] = r[qvr_pkg::ResW-1] ? qvr_pkg::VecMin : qvr_pkg::VecMax;
      end else begin
        res_d[i] = r[qvr_pkg::VecW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4) begin
      res_q   <= res_d;
      clip_q  <= |clip_d;
      last4_q <= last3_q;
    end
  end

  assign out_valid_o = v4_q;
  assign out_x_o     = res_q[0];
  assign out_y_o     = res_q[1];
  assign out_z_o     = res_q[2];
  assign clipped_o   = clip_q;
  assign last_out_o  = last4_q;

  // Input is held off only when the whole pipeline is full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (v1_q && v2_q && v3_q && v4_q))
    else $error("input stalled while a pipeline stage is empty");

  // An accepted request always lands in the first stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> v1_q)
    else $error("accepted request missing from stage 1");

  // A held stage 3 never drops its item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && !en3) |=> v3_q)
    else $error("stage 3 item lost during stall");

  // A clipped result has at least one component at a limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && clipped_o) |->
      (out_x_o == qvr_pkg::VecMax || out_x_o == qvr_pkg::VecMin ||
       out_y_o == qvr_pkg::VecMax || out_y_o == qvr_pkg::VecMin ||
       out_z_o == qvr_pkg::VecMax || out_z_o == qvr_pkg::VecMin))
    else $error("clipped set without a saturated component");

endmodule

/* dv/tb.sv */
// tb: self-checking bench for quaternion_vector_rotator, with a cycle-free predictor.
// Streams directed and random vector requests under several quaternion settings.
// Depends on qvr_pkg and the rotator RTL only.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned IdleLimit  = 4000;  // cycles without any handshake
  localparam int unsigned LongHold   = 300;   // receiver hold-off, in cycles
  localparam int unsigned RandPhases = 5;
  localparam int unsigned PhaseVecs  = 115;
  localparam int unsigned MaxReports = 10;

  localparam logic signed [95:0] RoundHalf = 96'sd134217728;  // 2^27

  typedef struct packed {
    qvr_pkg::vec_t x;
    qvr_pkg::vec_t y;
    qvr_pkg::vec_t z;
    logic last;
  } vec_item_t;

  typedef struct packed {
    qvr_pkg::vec_t x;
    qvr_pkg::vec_t y;
    qvr_pkg::vec_t z;
    logic clip;
    logic last;
  } rot_res_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HALF,
    STALL_HEAVY
  } stall_mode_e;

  logic                        clk_i       = 1'b0;
  logic                        rst_ni      = 1'b0;
  logic                        cfg_we_i    = 1'b0;
  logic [qvr_pkg::CfgIdxW-1:0] cfg_idx_i   = '0;
  logic [qvr_pkg::QuatW-1:0]   cfg_wdata_i = '0;
  logic                        in_valid_i  = 1'b0;
  logic                        in_stall_o;
  qvr_pkg::vec_t               in_x_i      = '0;
  qvr_pkg::vec_t               in_y_i      = '0;
  qvr_pkg::vec_t               in_z_i      = '0;
  logic                        last_in_i   = 1'b0;
  logic                        out_valid_o;
  logic                        out_stall_i = 1'b0;
  qvr_pkg::vec_t               out_x_o;
  qvr_pkg::vec_t               out_y_o;
  qvr_pkg::vec_t               out_z_o;
  logic                        clipped_o;
  logic                        last_out_o;

  // Bench copy of the quaternion registers
  qvr_pkg::quat_t rot_w = qvr_pkg::QuatOne;
  qvr_pkg::quat_t rot_x = '0;
  qvr_pkg::quat_t rot_y = '0;
  qvr_pkg::quat_t rot_z = '0;

  vec_item_t vec_pend[$];   // requests not yet offered
  rot_res_t  rot_exp[$];    // rotated vectors still owed by the block

  int unsigned n_vec_in = 0;
  int unsigned n_res    = 0;
  int unsigned n_clip   = 0;
  int unsigned n_last   = 0;
  int unsigned n_cfg    = 0;
  int unsigned n_err    = 0;

  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;
  int unsigned hold_left  = 0;
  bit          hold_done  = 1'b0;
  int unsigned mode_left  = 0;
  stall_mode_e stall_mode = STALL_NONE;
  int unsigned idle_cyc   = 0;

  always #10 clk_i = ~clk_i;

  quaternion_vector_rotator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_x_i      (in_x_i),
    .in_y_i      (in_y_i),
    .in_z_i      (in_z_i),
    .last_in_i   (last_in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_x_o     (out_x_o),
    .out_y_o     (out_y_o),
    .out_z_o     (out_z_o),
    .clipped_o   (clipped_o),
    .last_out_o  (last_out_o)
  );

  // Exact rotation: M v with M in Q.28, one round-half-up step, then clamp
  function automatic rot_res_t rotate_vec(vec_item_t v);
    logic signed [95:0] w, x, y, z, ww, xx, yy, zz, acc, r;
    logic signed [95:0] m [3][3];
    logic signed [95:0] c [3];
    qvr_pkg::vec_t      o [3];
    rot_res_t           res;
    w  = rot_w;
    x  = rot_x;
    y  = rot_y;
    z  = rot_z;
    ww = w * w;
    xx = x * x;
    yy = y * y;
    zz = z * z;
    m[0][0] = ww + xx - yy - zz;
    m[0][1] = 2 * (x * y - w * z);
    m[0][2] = 2 * (x * z + w * y);
    m[1][0] = 2 * (x * y + w * z);
    m[1][1] = ww - xx + yy - zz;
    m[1][2] = 2 * (y * z - w * x);
    m[2][0] = 2 * (x * z - w * y);
    m[2][1] = 2 * (y * z + w * x);
    m[2][2] = ww - xx - yy + zz;
    c[0] = $signed(v.x);
    c[1] = $signed(v.y);
    c[2] = $signed(v.z);
    res.clip = 1'b0;
    for (int i = 0; i < 3; i++) begin
      acc = m[i][0] * c[0] + m[i][1] * c[1] + m[i][2] * c[2];
      r   = (acc + RoundHalf) >>> qvr_pkg::FracDrop;
      if (r > qvr_pkg::VecMax) begin
        o[i]     = qvr_pkg::VecMax;
        res.clip = 1'b1;
      end else if (r < qvr_pkg::VecMin) begin
        o[i]     = qvr_pkg::VecMin;
        res.clip = 1'b1;
      end else begin
        o[i] = r[qvr_pkg::VecW-1:0];
      end
    end
    res.x    = o[0];
    res.y    = o[1];
    res.z    = o[2];
    res.last = v.last;
    return res;
  endfunction

  function automatic qvr_pkg::quat_t rand_quat();
    case ($urandom_range(0, 3))
      0: return qvr_pkg::quat_t'($urandom);
      1: begin
        case ($urandom_range(0, 4))
          0:       return 16'sh7fff;
          1:       return 16'sh8000;
          2:       return qvr_pkg::QuatOne;
          3:       return -qvr_pkg::QuatOne;
          default: return '0;
        endcase
      end
      default: return qvr_pkg::quat_t'($urandom_range(0, 32767)) - 16'sd16384;
    endcase
  endfunction

  function automatic qvr_pkg::vec_t rand_comp();
    case ($urandom_range(0, 4))
      0: return qvr_pkg::vec_t'($urandom_range(0, 32'h001f_ffff)) - 32'sh0010_0000;
      1: return qvr_pkg::vec_t'($urandom_range(0, 32'h1fff_ffff)) - 32'sh1000_0000;
      2: begin
        case ($urandom_range(0, 3))
          0:       return qvr_pkg::VecMax;
          1:       return qvr_pkg::VecMin;
          2:       return -32'sd1;
          default: return 32'sh0001_0000;
        endcase
      end
      default: return qvr_pkg::vec_t'($urandom);
    endcase
  endfunction

  task automatic queue_vec(qvr_pkg::vec_t x, qvr_pkg::vec_t y, qvr_pkg::vec_t z, logic last);
    vec_item_t it;
    it.x    = x;
    it.y    = y;
    it.z    = z;
    it.last = last;
    vec_pend.push_back(it);
  endtask

  task automatic cfg_write(qvr_pkg::cfg_idx_e idx, qvr_pkg::quat_t val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      qvr_pkg::CFG_QUAT_W: rot_w = val;
      qvr_pkg::CFG_QUAT_X: rot_x = val;
      qvr_pkg::CFG_QUAT_Y: rot_y = val;
      qvr_pkg::CFG_QUAT_Z: rot_z = val;
      default: ;
    endcase
    n_cfg++;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_quat(qvr_pkg::quat_t w, qvr_pkg::quat_t x, qvr_pkg::quat_t y,
                          qvr_pkg::quat_t z);
    cfg_write(qvr_pkg::CFG_QUAT_W, w);
    cfg_write(qvr_pkg::CFG_QUAT_X, x);
    cfg_write(qvr_pkg::CFG_QUAT_Y, y);
    cfg_write(qvr_pkg::CFG_QUAT_Z, z);
    repeat (2) @(posedge clk_i);
  endtask

  // Block drained: nothing pending, nothing offered, nothing owed, pipe flushed
  task automatic settle();
    while (vec_pend.size() != 0 || in_valid_i || rot_exp.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  // Sender: bursts of requests with random gaps in between
  always @(posedge clk_i) begin : drive_vec
    vec_item_t nxt;
    vec_item_t took;
    logic      busy;
    busy = in_valid_i;
    if (in_valid_i && !in_stall_o) begin
      took.x    = in_x_i;
      took.y    = in_y_i;
      took.z    = in_z_i;
      took.last = last_in_i;
      rot_exp.push_back(rotate_vec(took));
      n_vec_in++;
      busy = 1'b0;
    end
    if (!busy) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (vec_pend.size() > 0) begin
        nxt = vec_pend.pop_front();
        in_x_i     <= nxt.x;
        in_y_i     <= nxt.y;
        in_z_i     <= nxt.z;
        last_in_i  <= nxt.last;
        in_valid_i <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver stall pattern, plus one long hold-off while requests keep coming
  always @(posedge clk_i) begin : stall_gen
    if (!hold_done && n_vec_in >= 200 && vec_pend.size() > 40) begin
      hold_left = LongHold;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = stall_mode_e'($urandom_range(0, 3));
        mode_left  = $urandom_range(10, 80);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        STALL_NONE:  out_stall_i <= 1'b0;
        STALL_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
        STALL_HALF:  out_stall_i <= ($urandom_range(0, 1) == 0);
        STALL_HEAVY: out_stall_i <= ($urandom_range(0, 3) != 0);
        default:     out_stall_i <= 1'b0;
      endcase
    end
  end

  // Result checker: in-order compare against the oldest owed rotation
  always @(posedge clk_i) begin : check_res
    rot_res_t want;
    rot_res_t got;
    if (out_valid_o && !out_stall_i) begin
      got.x    = out_x_o;
      got.y    = out_y_o;
      got.z    = out_z_o;
      got.clip = clipped_o;
      got.last = last_out_o;
      n_res++;
      if (rot_exp.size() == 0) begin
        n_err++;
        if (n_err <= MaxReports)
          $display("unexpected result x=%h y=%h z=%h clip=%b last=%b",
                   got.x, got.y, got.z, got.clip, got.last);
      end else begin
        want = rot_exp.pop_front();
        if (want.clip) n_clip++;
        if (want.last) n_last++;
        if (got !== want) begin
          n_err++;
          if (n_err <= MaxReports)
            $display({"result %0d: exp x=%h y=%h z=%h clip=%b last=%b,",
                      " got x=%h y=%h z=%h clip=%b last=%b"},
                     n_res, want.x, want.y, want.z, want.clip, want.last,
                     got.x, got.y, got.z, got.clip, got.last);
        end
      end
    end
  end

  // Watchdog on handshake progress
  always @(posedge clk_i) begin : watchdog
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) begin
      idle_cyc <= 0;
    end else if (idle_cyc >= IdleLimit) begin
      $display("watchdog: no handshake for %0d cycles, %0d results owed",
               idle_cyc, rot_exp.size());
      $display("tb: errors");
      $finish;
    end else begin
      idle_cyc <= idle_cyc + 1;
    end
  end

  initial begin : run
    qvr_pkg::cfg_idx_e idx;
    bit                wrote;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    // Reset quaternion is the identity
    queue_vec('0, '0, '0, 1'b0);
    queue_vec(qvr_pkg::VecMax, qvr_pkg::VecMin, -32'sd1, 1'b1);
    queue_vec(qvr_pkg::VecMin, qvr_pkg::VecMax, 32'sd1, 1'b0);
    queue_vec(32'sh0001_0000, -32'sh0001_0000, 32'sh5555_5555, 1'b1);
    queue_vec(32'shaaaa_aaaa, 32'sh7fff_0000, 32'sh8000_ffff, 1'b0);
    settle();

    // All components at their extremes: heavy scaling, clamping
    set_quat(16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000);
    queue_vec(qvr_pkg::VecMax, qvr_pkg::VecMax, qvr_pkg::VecMax, 1'b0);
    queue_vec(qvr_pkg::VecMin, qvr_pkg::VecMin, qvr_pkg::VecMin, 1'b1);
    queue_vec(qvr_pkg::VecMax, qvr_pkg::VecMin, '0, 1'b0);
    queue_vec(32'sd1, -32'sd1, 32'sd1, 1'b0);
    queue_vec('0, '0, '0, 1'b1);
    queue_vec(32'sh0001_0000, '0, '0, 1'b0);
    settle();

    // Quarter scale on each axis: x/4 hits exact rounding ties both ways
    set_quat(16'sd8192, '0, '0, '0);
    queue_vec(32'sd2, -32'sd2, 32'sd6, 1'b0);
    queue_vec(-32'sd6, 32'sd10, -32'sd10, 1'b1);
    queue_vec(qvr_pkg::VecMax, qvr_pkg::VecMin, 32'sd3, 1'b0);
    settle();

    // Scale by four: values right at and just past the clamp limits
    set_quat(16'sh8000, '0, '0, '0);
    queue_vec(qvr_pkg::VecMin, 32'sh2000_0000, 32'sh1fff_ffff, 1'b0);
    queue_vec(qvr_pkg::VecMax, -32'sh2000_0000, -32'sh2000_0001, 1'b1);
    settle();

    // Random phases, each under a partly rewritten quaternion
    for (int ph = 0; ph < RandPhases; ph++) begin
      wrote = 1'b0;
      idx   = qvr_pkg::CFG_QUAT_W;
      repeat (4) begin
        if ($urandom_range(0, 1) == 1) begin
          cfg_write(idx, rand_quat());
          wrote = 1'b1;
        end
        idx = idx.next();
      end
      if (!wrote) cfg_write(qvr_pkg::CFG_QUAT_W, rand_quat());
      repeat (2) @(posedge clk_i);
      repeat (PhaseVecs)
        queue_vec(rand_comp(), rand_comp(), rand_comp(), $urandom_range(0, 7) == 0);
      settle();
    end

    repeat (4) @(posedge clk_i);
    $display("summary: %0d vectors in, %0d results, %0d clamped, %0d batch ends", n_vec_in,
             n_res, n_clip, n_last);
    $display("summary: %0d quaternion writes, %0d mismatches", n_cfg, n_err);
    if (n_err == 0 && rot_exp.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
